FILE: src/zwm_pkg.sv
`timescale 1ns / 1ps
// Package for the zone weight map engine: map sizes, command codes, state
// type and the channel word types. No dependencies.
package zwm_pkg;
	localparam int MAP_WIDTH  = 64;
	localparam int MAP_HEIGHT = 48;
	localparam int MAP_SIZE   = MAP_WIDTH * MAP_HEIGHT;
	localparam int COL_W      = $clog2(MAP_WIDTH);
	localparam int ROW_W      = $clog2(MAP_HEIGHT);
	localparam int ADDR_W     = $clog2(MAP_SIZE);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDESCREEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT   = 1'd1;
	localparam logic [6:0] WS_LOW  = 7'(MAP_HEIGHT / 8);
	localparam logic [6:0] WS_HIGH = 7'((7 * MAP_HEIGHT) / 8);

	typedef enum logic [2:0] {
		CMD_FILL   = 3'd0,
		CMD_LEFT   = 3'd1,
		CMD_RIGHT  = 3'd2,
		CMD_TOP    = 3'd3,
		CMD_BOTTOM = 3'd4,
		CMD_WRITE  = 3'd5,
		CMD_QUERY  = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SWEEP, ST_READ, ST_LOAD, ST_POW, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [6:0] span_first;
		logic [6:0] span_end;
		logic [5:0] row;
		logic [5:0] col;
		logic [7:0] value;
	} in_word_t;

	typedef struct packed {
		logic [7:0] weight;
	} out_word_t;
endpackage

FILE: src/zwm_in_if.sv
`timescale 1ns / 1ps
// Command channel interface: valid/ready handshake carrying one command word.
// Depends on zwm_pkg.
interface zwm_in_if;
	logic              valid;
	logic              ready;
	zwm_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/zwm_out_if.sv
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake carrying one weight word.
// Depends on zwm_pkg.
interface zwm_out_if;
	logic               valid;
	logic               ready;
	zwm_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/zone_weight_map_engine_top.sv
`timescale 1ns / 1ps
// Zone weight map engine, top level. Depends on zwm_pkg, zwm_in_if, zwm_out_if, zwm_ram.
// Query (n = edge_exponent): RAM read, load, n power steps (the last aligns the divisor),
// 8 restoring divide steps, then the result is valid; off-map pixels, blanked rows and n of zero
// answer in the cycle after the accepting edge. Result held until taken; ready only in idle.
// Write pixel, fill and gradients store one map entry a cycle (fill: all MAP_WIDTH*MAP_HEIGHT).
// Reset clears the state and the configuration registers (widescreen 0, exponent 1); map undefined.
module zone_weight_map_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [zwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [zwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	zwm_in_if.sink                            cmd_in,
	zwm_out_if.source                         res_out
);
	import zwm_pkg::*;

	state_t            state_q, state_nx, start_nx;
	logic              ws_q;
	logic [2:0]        exp_q;
	logic [2:0]        cmd_q;
	logic [7:0]        value_q;
	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic [COL_W-1:0]  c_lo_q;
	logic [COL_W:0]    c_hi_q;
	logic [ROW_W:0]    r_hi_q;
	logic [55:0]       acc_q;     // power, then running remainder
	logic [55:0]       dvsr_q;    // 255^(n-1), then shifted divisor
	logic [2:0]        cnt_q;
	logic [7:0]        w_q;
	logic [7:0]        quo_q;
	logic [7:0]        res_q;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic [7:0]        grad;
	logic [7:0]        col_grad [MAP_WIDTH];
	logic [7:0]        row_grad [MAP_HEIGHT];
	in_word_t          in_w;
	logic [6:0]        f_cl, e_cl;
	logic              rows_cmd, in_map, blank_row, span_ok;
	logic [55:0]       prod;
	logic              q_bit;
	logic              sweep_last_col, sweep_last_row;

	assign cmd_in.ready        = (state_q == ST_IDLE);
	assign res_out.valid       = (state_q == ST_OUT);
	assign res_out.data.weight = res_q;

	// decode the incoming word
	assign in_w      = cmd_in.data;
	assign in_map    = (7'(in_w.row) < 7'(MAP_HEIGHT)) && (7'(in_w.col) < 7'(MAP_WIDTH));
	assign blank_row = ws_q && (7'(in_w.row) <= WS_LOW || 7'(in_w.row) >= WS_HIGH);
	assign rows_cmd  = (in_w.cmd == CMD_LEFT) || (in_w.cmd == CMD_RIGHT);

	// clamp span ends to the map size
	always_comb begin
		f_cl = in_w.span_first;
		e_cl = in_w.span_end;
		if (rows_cmd) begin
			if (f_cl > 7'(MAP_HEIGHT)) f_cl = 7'(MAP_HEIGHT);
			if (e_cl > 7'(MAP_HEIGHT)) e_cl = 7'(MAP_HEIGHT);
		end else begin
			if (f_cl > 7'(MAP_WIDTH)) f_cl = 7'(MAP_WIDTH);
			if (e_cl > 7'(MAP_WIDTH)) e_cl = 7'(MAP_WIDTH);
		end
	end
	assign span_ok = (f_cl < e_cl);

	// constant gradient tables
	for (genvar gi = 0; gi < MAP_WIDTH; gi++) begin : g_col_grad
		assign col_grad[gi] = 8'((255 * gi) / (MAP_WIDTH - 1));
	end
	for (genvar gi = 0; gi < MAP_HEIGHT; gi++) begin : g_row_grad
		assign row_grad[gi] = 8'((255 * gi) / (MAP_HEIGHT - 1));
	end

	// value stored at the current sweep position
	always_comb begin
		case (cmd_q)
			CMD_LEFT:   grad = col_grad[COL_W'(MAP_WIDTH - 1) - c_q];
			CMD_RIGHT:  grad = col_grad[c_q];
			CMD_TOP:    grad = row_grad[ROW_W'(MAP_HEIGHT - 1) - r_q];
			CMD_BOTTOM: grad = row_grad[r_q];
			default:    grad = value_q;
		endcase
	end

	// RAM access
	assign ram_we    = (state_q == ST_SWEEP);
	assign ram_addr  = ADDR_W'(r_q) * ADDR_W'(MAP_WIDTH) + ADDR_W'(c_q);
	assign ram_wdata = grad;

	zwm_ram #(.WIDTH(8), .DEPTH(MAP_SIZE)) u_map (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// shared multiplier and divide step compare
	assign prod  = acc_q * 56'(w_q);
	assign q_bit = (acc_q >= dvsr_q);

	assign sweep_last_col = ({1'b0, c_q} == c_hi_q - 1'b1);
	assign sweep_last_row = ({1'b0, r_q} == r_hi_q - 1'b1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q  <= 1'b0;
			exp_q <= 3'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDESCREEN) ws_q <= cfg_data[0];
			if (cfg_index == REG_EXPONENT)   exp_q <= cfg_data[2:0];
		end
	end

	// first state for an accepted word
	always_comb begin
		unique case (in_w.cmd)
			CMD_FILL:  start_nx = ST_SWEEP;
			CMD_WRITE: start_nx = in_map ? ST_SWEEP : ST_IDLE;
			CMD_QUERY: start_nx = (in_map && !blank_row && exp_q != 3'd0) ? ST_READ : ST_OUT;
			CMD_NONE:  start_nx = ST_IDLE;
			default:   start_nx = span_ok ? ST_SWEEP : ST_IDLE;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (cmd_in.valid) state_nx = start_nx;
			ST_SWEEP: if (sweep_last_col && sweep_last_row) state_nx = ST_IDLE;
			ST_READ:  state_nx = ST_LOAD;
			ST_LOAD:  state_nx = ST_POW;
			ST_POW:   if (cnt_q == 3'd0) state_nx = ST_DIV;
			ST_DIV:   if (cnt_q == 3'd0) state_nx = ST_OUT;
			ST_OUT:   if (res_out.ready) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	// datapath sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_in.valid) begin
					cmd_q   <= in_w.cmd;
					value_q <= in_w.value;
					res_q   <= (in_map && !blank_row) ? 8'd255 : 8'd0;
					if (in_w.cmd == CMD_FILL) begin
						r_q    <= '0;
						c_q    <= '0;
						c_lo_q <= '0;
						c_hi_q <= (COL_W+1)'(MAP_WIDTH);
						r_hi_q <= (ROW_W+1)'(MAP_HEIGHT);
					end else if (rows_cmd) begin
						r_q    <= ROW_W'(f_cl);
						c_q    <= '0;
						c_lo_q <= '0;
						c_hi_q <= (COL_W+1)'(MAP_WIDTH);
						r_hi_q <= (ROW_W+1)'(e_cl);
					end else if (in_w.cmd == CMD_TOP || in_w.cmd == CMD_BOTTOM) begin
						r_q    <= '0;
						c_q    <= COL_W'(f_cl);
						c_lo_q <= COL_W'(f_cl);
						c_hi_q <= (COL_W+1)'(e_cl);
						r_hi_q <= (ROW_W+1)'(MAP_HEIGHT);
					end else begin
						r_q    <= ROW_W'(in_w.row);
						c_q    <= COL_W'(in_w.col);
						c_lo_q <= COL_W'(in_w.col);
						c_hi_q <= {1'b0, COL_W'(in_w.col)} + 1'b1;
						r_hi_q <= {1'b0, ROW_W'(in_w.row)} + 1'b1;
					end
				end
			end
			ST_SWEEP: begin
				// advance along the row, wrap to the span start
				if (sweep_last_col) begin
					c_q <= c_lo_q;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			ST_LOAD: begin
				w_q    <= ram_rdata;
				acc_q  <= 56'(ram_rdata);
				dvsr_q <= 56'd1;
				cnt_q  <= exp_q - 3'd1;
			end
			ST_POW: begin
				// raise the power and the divisor, then align the divisor
				if (cnt_q != 3'd0) begin
					acc_q  <= prod;
					dvsr_q <= (dvsr_q << 8) - dvsr_q;
					cnt_q  <= cnt_q - 3'd1;
				end else begin
					dvsr_q <= dvsr_q << 7;
					quo_q  <= '0;
					cnt_q  <= 3'd7;
				end
			end
			ST_DIV: begin
				// restoring division, one quotient bit a cycle
				if (q_bit) acc_q <= acc_q - dvsr_q;
				dvsr_q <= dvsr_q >> 1;
				quo_q  <= {quo_q[6:0], q_bit};
				cnt_q  <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) res_q <= {quo_q[6:0], q_bit};
			end
			default: ;
		endcase
	end

	// handshake and sequencing checks
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.data.weight));
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_in.ready && res_out.valid));
	a_wr_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_addr < ADDR_W'(MAP_SIZE)));
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> (state_q == ST_IDLE));
endmodule

FILE: src/zwm_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module zwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one entry when enabled; read the addressed entry every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
